// ----- hw/rtl/afrb_pkg.sv -----
// ----------------------------------------------------------------------------
// afrb_pkg: audio frame ring buffer shared definitions
// Sizes, command codes, channel beat types and the bundles passed between
// the front, the back and the byte RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package afrb_pkg;

  // Ring geometry: FRAME_SLOTS frames of FRAME_BYTES bytes each.
  localparam int FRAME_BYTES = 4 * 1024;
  localparam int FRAME_SLOTS = 4;
  localparam int RING_BYTES  = FRAME_BYTES * FRAME_SLOTS;

  localparam int PTR_W  = $clog2(RING_BYTES);   // ring address
  localparam int FILL_W = PTR_W + 1;            // 0 .. RING_BYTES
  localparam int OFF_W  = $clog2(FRAME_BYTES);  // position inside a frame
  localparam int TAKE_W = OFF_W + 1;            // 0 .. FRAME_BYTES

  // Command queue between front and back, and result buffer depth.
  localparam int Q_DEPTH   = 2;
  localparam int OUT_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        padded;
    logic        frame_end;
    logic        overflow;
    logic [14:0] fill_level;
    logic        play_ready;
    logic        want_data;
  } res_t;

  // Classified operation handed from front to back.
  typedef struct packed {
    logic       is_push;
    logic       is_pull;
    logic       is_clear;
    logic [7:0] data;
  } op_t;

  // Byte RAM access issued by the back.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [PTR_W-1:0] addr;
    logic [7:0]       wdata;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/audio_frame_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// audio_frame_ring_buffer: byte ring buffer feeding an audio output by frame
// Push stores bytes into a ring of FRAME_SLOTS frames; pull hands out one
// byte of the current output frame, zero-padded on underrun; clear empties.
// ----------------------------------------------------------------------------
//
//   channel  direction  beat type         handshake
//   in_      input      afrb_pkg::in_t    in_valid / in_ready
//   out_     output     afrb_pkg::res_t   out_valid / out_ready
//
// One beat per cycle in both directions when out_ready stays high. A result
// passes the command queue, the stage that waits for the registered read of
// the byte RAM and the result buffer before it leaves.
// Reset clears pointers, fill count and frame position at once; the byte RAM
// needs no clearing pass since only bytes counted in the fill are read.
// An output stall fills the two-entry result buffer, then the command queue;
// in_ready drops only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_frame_ring_buffer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire afrb_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output afrb_pkg::res_t       out_data
);

  logic                 op_valid;
  logic                 op_ready;
  afrb_pkg::op_t        op;
  afrb_pkg::ram_req_t   ram_req;
  logic [7:0]           ram_rdata;

  // Front: accept and classify beats, hold them in the command queue.
  afrb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  // Back: advance pointers and fill count, build results.
  afrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Ring storage; one access per cycle, write or read.
  afrb_ram #(
    .WIDTH (8),
    .DEPTH (afrb_pkg::RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/afrb_ram.sv -----
// ----------------------------------------------------------------------------
// afrb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module afrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/afrb_front.sv -----
// ----------------------------------------------------------------------------
// afrb_front: input decode and command queue
// Accept input beats, classify the command and hold it in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module afrb_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire afrb_pkg::in_t   in_data,
  output logic                 op_valid,
  input  wire logic            op_ready,
  output afrb_pkg::op_t        op
);

  localparam int QA_W = $clog2(afrb_pkg::Q_DEPTH);

  afrb_pkg::op_t     q_r [afrb_pkg::Q_DEPTH];
  logic [QA_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QA_W:0]     cnt_r, cnt_nxt;
  afrb_pkg::op_t     dec;
  logic              push, pop;

  // Classify the command; the unused code becomes a plain status beat.
  always_comb begin
    dec = '0;
    dec.data = in_data.in_byte;
    case (afrb_pkg::cmd_e_t'(in_data.command))
      afrb_pkg::CMD_PUSH:  dec.is_push  = 1'b1;
      afrb_pkg::CMD_PULL:  dec.is_pull  = 1'b1;
      afrb_pkg::CMD_CLEAR: dec.is_clear = 1'b1;
      default:             dec.is_push  = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r < (QA_W+1)'(afrb_pkg::Q_DEPTH));
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rp_r];
  assign push     = in_valid & in_ready;
  assign pop      = op_valid & op_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QA_W'(afrb_pkg::Q_DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QA_W'(afrb_pkg::Q_DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QA_W+1)'(afrb_pkg::Q_DEPTH))
    else $error("command queue count out of range");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue lost a beat");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("command queue count did not drop on pop");

endmodule

`default_nettype wire

// ----- hw/rtl/afrb_back.sv -----
// ----------------------------------------------------------------------------
// afrb_back: ring control and result buffer
// Execute queued commands against the pointers and fill count, drive the
// byte RAM and buffer results for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module afrb_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 op_valid,
  output logic                      op_ready,
  input  wire afrb_pkg::op_t        op,
  output afrb_pkg::ram_req_t        ram_req,
  input  wire logic [7:0]           ram_rdata,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output afrb_pkg::res_t            out_data
);

  localparam int PTR_W  = afrb_pkg::PTR_W;
  localparam int FILL_W = afrb_pkg::FILL_W;
  localparam int OFF_W  = afrb_pkg::OFF_W;
  localparam int TAKE_W = afrb_pkg::TAKE_W;
  localparam int OA_W   = $clog2(afrb_pkg::OUT_DEPTH);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [OFF_W-1:0]  foff_r, foff_nxt;
  logic [TAKE_W-1:0] ftake_r, ftake_nxt, take, take_new;

  logic              issue, real_byte;
  afrb_pkg::res_t    res;

  // Result held in a register while the RAM read data arrives.
  logic              s1_v_r;
  logic              s1_real_r;
  afrb_pkg::res_t    s1_res_r;

  // Result buffer.
  afrb_pkg::res_t    ob_r [afrb_pkg::OUT_DEPTH];
  logic [OA_W-1:0]   owp_r, owp_nxt, orp_r, orp_nxt;
  logic [OA_W:0]     ocnt_r, ocnt_nxt, occ;
  logic              opush, opop;
  afrb_pkg::res_t    oentry;

  // Issue only when the result buffer can absorb this result too.
  assign opop     = out_valid & out_ready;
  assign occ      = ocnt_r + (OA_W+1)'(s1_v_r) - (OA_W+1)'(opop);
  assign op_ready = (occ < (OA_W+1)'(afrb_pkg::OUT_DEPTH));
  assign issue    = op_valid & op_ready;

  assign take_new = (fill_r < FILL_W'(afrb_pkg::FRAME_BYTES))
                    ? fill_r[TAKE_W-1:0] : TAKE_W'(afrb_pkg::FRAME_BYTES);

  always_comb begin
    fill_nxt  = fill_r;
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    foff_nxt  = foff_r;
    ftake_nxt = ftake_r;
    take      = ftake_r;
    real_byte = 1'b0;
    res       = '0;
    ram_req   = '0;
    ram_req.wdata = op.data;
    ram_req.addr  = op.is_push ? wptr_r : rptr_r;
    if (issue) begin
      if (op.is_push) begin
        if (fill_r >= FILL_W'(afrb_pkg::RING_BYTES)) begin
          res.overflow = 1'b1;  // drop the byte
        end else begin
          ram_req.we = 1'b1;
          wptr_nxt   = (wptr_r == PTR_W'(afrb_pkg::RING_BYTES-1)) ? '0 : wptr_r + 1'b1;
          fill_nxt   = fill_r + 1'b1;
        end
      end else if (op.is_pull) begin
        res.out_valid = 1'b1;
        take      = (foff_r == '0) ? take_new : ftake_r;
        ftake_nxt = take;
        if (({1'b0, foff_r} < take) && (fill_r != '0)) begin
          real_byte  = 1'b1;
          ram_req.re = 1'b1;
          rptr_nxt   = (rptr_r == PTR_W'(afrb_pkg::RING_BYTES-1)) ? '0 : rptr_r + 1'b1;
          fill_nxt   = fill_r - 1'b1;
        end else begin
          res.padded = 1'b1;
        end
        if (foff_r == OFF_W'(afrb_pkg::FRAME_BYTES-1)) begin
          res.frame_end = 1'b1;
          foff_nxt      = '0;
        end else begin
          foff_nxt = foff_r + 1'b1;
        end
      end else if (op.is_clear) begin
        fill_nxt  = '0;
        wptr_nxt  = '0;
        rptr_nxt  = '0;
        foff_nxt  = '0;
        ftake_nxt = '0;
      end
    end
    res.fill_level = fill_nxt;
    res.play_ready = (fill_nxt >= FILL_W'(afrb_pkg::FRAME_BYTES));
    res.want_data  = (fill_nxt < FILL_W'(2 * afrb_pkg::FRAME_BYTES));
  end

  // Result buffer bookkeeping; the RAM byte joins the result here.
  assign opush = s1_v_r;
  always_comb begin
    oentry = s1_res_r;
    oentry.out_byte = s1_real_r ? ram_rdata : 8'd0;
    owp_nxt  = owp_r;
    orp_nxt  = orp_r;
    ocnt_nxt = ocnt_r;
    if (opush) begin
      owp_nxt = (owp_r == OA_W'(afrb_pkg::OUT_DEPTH-1)) ? '0 : owp_r + 1'b1;
    end
    if (opop) begin
      orp_nxt = (orp_r == OA_W'(afrb_pkg::OUT_DEPTH-1)) ? '0 : orp_r + 1'b1;
    end
    if (opush && !opop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (opop && !opush) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  assign out_valid = (ocnt_r != '0);
  assign out_data  = ob_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      wptr_r  <= '0;
      rptr_r  <= '0;
      foff_r  <= '0;
      ftake_r <= '0;
      s1_v_r  <= 1'b0;
      owp_r   <= '0;
      orp_r   <= '0;
      ocnt_r  <= '0;
    end else begin
      fill_r  <= fill_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      foff_r  <= foff_nxt;
      ftake_r <= ftake_nxt;
      s1_v_r  <= issue;
      owp_r   <= owp_nxt;
      orp_r   <= orp_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_res_r  <= res;
    s1_real_r <= real_byte;
    if (opush) begin
      ob_r[owp_r] <= oentry;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(afrb_pkg::RING_BYTES))
    else $error("fill count above ring size");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W'(wptr_r - rptr_r) == fill_r[PTR_W-1:0]))
    else $error("pointers disagree with fill count");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r + (OA_W+1)'(s1_v_r)) <= (OA_W+1)'(afrb_pkg::OUT_DEPTH))
    else $error("result buffer overrun");

endmodule

`default_nettype wire

// ----- tb/audio_frame_ring_buffer_test.sv -----
// ----------------------------------------------------------------------------
// audio_frame_ring_buffer_test: self-checking bench for the frame ring buffer
// Drives push, pull, clear and unused commands through the valid/ready input
// channel. A scoreboard predicts every result beat from its own model of the
// ring, pointers, fill count and frame position. Random idling sits on both
// channels, and one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_frame_ring_buffer_test;

  // Long output hold-off, in cycles, used once to back the block up.
  localparam int LONG_HOLD = 400;
  // Runaway guard, in time units.
  localparam int RUN_LIMIT = 60_000_000;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the ring contents and frame position, queues the
  // expected result of every accepted command and checks the result beats.
  // --------------------------------------------------------------------------
  class frame_ring_scoreboard;
    bit   [7:0]                  ring [afrb_pkg::RING_BYTES];
    logic [afrb_pkg::PTR_W-1:0]  wr_ptr;
    logic [afrb_pkg::PTR_W-1:0]  rd_ptr;
    logic [afrb_pkg::FILL_W-1:0] level;
    logic [afrb_pkg::OFF_W-1:0]  offset;
    logic [afrb_pkg::TAKE_W-1:0] take;
    afrb_pkg::res_t              expected_results [$];
    int                          errors;
    int                          results_seen;
    int                          frame_ends;
    int                          pads;
    int                          overflows;

    function new();
      wr_ptr       = '0;
      rd_ptr       = '0;
      level        = '0;
      offset       = '0;
      take         = '0;
      errors       = 0;
      results_seen = 0;
      frame_ends   = 0;
      pads         = 0;
      overflows    = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the model by one accepted command and queue what it yields.
    function void accept_command(afrb_pkg::in_t beat);
      afrb_pkg::res_t r;
      r = '0;
      case (afrb_pkg::cmd_e_t'(beat.command))
        afrb_pkg::CMD_PUSH: begin
          // Full ring: drop the byte, flag it, leave everything else.
          if (level >= afrb_pkg::RING_BYTES) begin
            r.overflow = 1'b1;
          end else begin
            ring[wr_ptr] = beat.in_byte;
            wr_ptr = (wr_ptr == afrb_pkg::RING_BYTES - 1) ? '0 : wr_ptr + 1'b1;
            level  = level + 1'b1;
          end
        end
        afrb_pkg::CMD_PULL: begin
          r.out_valid = 1'b1;
          // Latch the real byte count at the first byte of a frame.
          if (offset == 0) begin
            take = (level < afrb_pkg::FRAME_BYTES) ? afrb_pkg::TAKE_W'(level)
                                                   : afrb_pkg::TAKE_W'(afrb_pkg::FRAME_BYTES);
          end
          if (offset < take && level > 0) begin
            r.out_byte = ring[rd_ptr];
            rd_ptr = (rd_ptr == afrb_pkg::RING_BYTES - 1) ? '0 : rd_ptr + 1'b1;
            level  = level - 1'b1;
          end else begin
            r.padded = 1'b1;
          end
          if (offset + 1 >= afrb_pkg::FRAME_BYTES) begin
            r.frame_end = 1'b1;
            offset = '0;
          end else begin
            offset = offset + 1'b1;
          end
        end
        afrb_pkg::CMD_CLEAR: begin
          // Stored bytes stay; only the bookkeeping goes back to empty.
          wr_ptr = '0;
          rd_ptr = '0;
          level  = '0;
          offset = '0;
          take   = '0;
        end
        default: begin
        end
      endcase
      r.fill_level = level;
      r.play_ready = (level >= afrb_pkg::FRAME_BYTES);
      r.want_data  = (level < 2 * afrb_pkg::FRAME_BYTES);
      expected_results.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("[%0t] MISMATCH at result %0d: %s got 0x%0h want 0x%0h",
               $time, results_seen, what, got, want);
    endtask

    task check_result(afrb_pkg::res_t got);
      afrb_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report("result with nothing pending", 32'(got), 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.out_byte   !== want.out_byte)   report("out_byte",   got.out_byte,   want.out_byte);
      if (got.out_valid  !== want.out_valid)  report("out_valid",  got.out_valid,  want.out_valid);
      if (got.padded     !== want.padded)     report("padded",     got.padded,     want.padded);
      if (got.frame_end  !== want.frame_end)  report("frame_end",  got.frame_end,  want.frame_end);
      if (got.overflow   !== want.overflow)   report("overflow",   got.overflow,   want.overflow);
      if (got.fill_level !== want.fill_level) report("fill_level", got.fill_level, want.fill_level);
      if (got.play_ready !== want.play_ready) report("play_ready", got.play_ready, want.play_ready);
      if (got.want_data  !== want.want_data)  report("want_data",  got.want_data,  want.want_data);
      results_seen++;
      frame_ends += want.frame_end;
      pads       += want.padded;
      overflows  += want.overflow;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block hookup
  // --------------------------------------------------------------------------
  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  afrb_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  afrb_pkg::res_t out_data;

  audio_frame_ring_buffer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  frame_ring_scoreboard sb;

  bit idle_en;     // random idling on both channels
  bit hold_req;    // ask the receiver for one long hold-off
  int beats_sent;

  // 10 time unit clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Result side: sample every accepted beat at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // Receiver: drive out_ready at the falling edge. Random stalls while idling
  // is on; one long hold-off when the sender asks.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // Count the long hold here so the sender keeps offering beats.
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Each one starts and ends at a falling edge. After a beat is
  // accepted, valid stays high so a back-to-back beat never toggles it.
  // --------------------------------------------------------------------------
  task automatic do_cmd(afrb_pkg::cmd_e_t c, logic [7:0] b);
    afrb_pkg::in_t beat;
    beat.command = c;
    beat.in_byte = b;
    // Drop valid for a random burst before some beats.
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_command(beat);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic push_run(int n);
    repeat (n) do_cmd(afrb_pkg::CMD_PUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic pull_run(int n);
    // The byte field of a pull is don't-care; randomize it anyway.
    repeat (n) do_cmd(afrb_pkg::CMD_PULL, 8'($urandom_range(0, 255)));
  endtask

  // Hold valid low until every queued expectation has been matched.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    int phase_start;
    sb         = new();
    idle_en    = 1'b1;
    hold_req   = 1'b0;
    beats_sent = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unused code, pulls on empty, a frame latched at zero bytes,
    // clear in mid-frame, a short real frame and underrun padding after it.
    do_cmd(afrb_pkg::CMD_NOP,   8'hFF);
    do_cmd(afrb_pkg::CMD_PULL,  8'h00);
    do_cmd(afrb_pkg::CMD_PUSH,  8'hFF);
    do_cmd(afrb_pkg::CMD_PULL,  8'hFF);   // still padded: this frame latched no bytes
    do_cmd(afrb_pkg::CMD_CLEAR, 8'h00);   // abandon the partial frame
    do_cmd(afrb_pkg::CMD_PUSH,  8'h00);
    do_cmd(afrb_pkg::CMD_PUSH,  8'hFF);
    do_cmd(afrb_pkg::CMD_PUSH,  8'h5A);
    do_cmd(afrb_pkg::CMD_PULL,  8'h00);
    do_cmd(afrb_pkg::CMD_PULL,  8'h00);
    do_cmd(afrb_pkg::CMD_PULL,  8'hFF);
    do_cmd(afrb_pkg::CMD_PULL,  8'h00);   // underrun inside the frame
    do_cmd(afrb_pkg::CMD_PUSH,  8'hA5);
    do_cmd(afrb_pkg::CMD_PULL,  8'h00);   // padded, frame took only three bytes
    do_cmd(afrb_pkg::CMD_CLEAR, 8'hFF);
    do_cmd(afrb_pkg::CMD_NOP,   8'h00);
    do_cmd(afrb_pkg::CMD_PULL,  8'hFF);
    do_cmd(afrb_pkg::CMD_CLEAR, 8'h00);
    do_cmd(afrb_pkg::CMD_PUSH,  8'h80);
    do_cmd(afrb_pkg::CMD_PUSH,  8'h01);
    do_cmd(afrb_pkg::CMD_PULL,  8'h00);
    do_cmd(afrb_pkg::CMD_PULL,  8'h00);

    // Random mix: push and pull runs of random length, odd clears, noise.
    phase_start = beats_sent;
    while (beats_sent < phase_start + 340) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_run($urandom_range(1, 24));
      end else if (pick < 75) begin
        pull_run($urandom_range(1, 24));
      end else if (pick < 88) begin
        do_cmd(afrb_pkg::cmd_e_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        do_cmd(afrb_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      end
    end
    wait_drained();

    // Long output hold while the sender keeps pushing, so the block backs up
    // into its input. The pulls after it land in a frame that latched fewer
    // bytes than are stored, so they pad.
    do_cmd(afrb_pkg::CMD_CLEAR, 8'h00);
    push_run(20);
    pull_run(20);
    hold_req <= 1'b1;
    push_run(40);
    pull_run(30);
    wait_drained();

    // Last stretch with no idling: a frame that runs dry partway and pads.
    idle_en = 1'b0;
    do_cmd(afrb_pkg::CMD_CLEAR, 8'h00);
    push_run(10);
    pull_run(12);
    push_run(3);
    pull_run(2);
    do_cmd(afrb_pkg::CMD_CLEAR, 8'hFF);
    do_cmd(afrb_pkg::CMD_NOP,   8'h00);
    pull_run(2);
    wait_drained();

    // Let the pipeline settle and catch any stray beat.
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report("results never arrived", sb.pending(), 0);
    end

    $display("Sent %0d command beats, checked %0d result beats.",
             beats_sent, sb.results_seen);
    $display("Saw %0d frame ends, %0d padded bytes and %0d dropped pushes.",
             sb.frame_ends, sb.pads, sb.overflows);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Runaway guard.
  initial begin
    #RUN_LIMIT;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/afrb_pkg.sv
hw/rtl/afrb_ram.sv
hw/rtl/afrb_front.sv
hw/rtl/afrb_back.sv
hw/rtl/audio_frame_ring_buffer.sv
tb/audio_frame_ring_buffer_test.sv
